// ===== src/olpe_pkg.sv =====
// Shared types and constants for the ordered list with positional edit.
// Holds operation codes, result status codes and the front-to-back command word.
// No dependencies.
package olpe_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned CAPACITY_MAX = 64;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;

  // Command fields sized for the largest supported capacity
  localparam int unsigned CMD_IDX_W = $clog2(CAPACITY_MAX);
  localparam int unsigned CMD_LEN_W = $clog2(CAPACITY_MAX + 1);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT  = 3'd0,
    MODE_PUSH_BACK   = 3'd1,
    MODE_POP_FRONT   = 3'd2,
    MODE_POP_BACK    = 3'd3,
    MODE_CLEAR       = 3'd4,
    MODE_INSERT_AFTER = 3'd5,
    MODE_REMOVE_AT   = 3'd6,
    MODE_DUMP        = 3'd7
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_OPEN   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    status_t              status;
    logic [CMD_IDX_W-1:0] idx;
    logic [CMD_LEN_W-1:0] len;
    logic [VAL_W-1:0]     value;
  } cmd_t;

endpackage

// ===== src/olpe_front.sv =====
// Front end: accepts input words, checks them against a shadow entry count
// and issues classified commands. Depends on olpe_pkg.
module olpe_front #(
  parameter int unsigned CAPACITY = olpe_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olpe_pkg::MODE_W-1:0]   in_mode,
  input  logic [olpe_pkg::POS_W-1:0]    in_position,
  input  logic signed [olpe_pkg::VAL_W-1:0] in_value,
  output logic                          q_push,
  output olpe_pkg::cmd_t                q_cmd,
  input  logic                          q_full
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > olpe_pkg::POS_W) ? CNT_W : olpe_pkg::POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_x;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic             pos_ok;
  olpe_pkg::cmd_t   cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign q_cmd    = cmd;

  assign cnt_x    = CMP_W'(count_r);
  assign pos_x    = CMP_W'(in_position);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_ok   = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    cmd        = '0;
    cmd.op     = olpe_pkg::OP_REPORT;
    cmd.status = olpe_pkg::ST_OK;
    cmd.value  = in_value;
    count_nxt  = count_r;
    unique case (olpe_pkg::mode_t'(in_mode))
      olpe_pkg::MODE_PUSH_FRONT: begin
        if (is_full) begin
          cmd.status = olpe_pkg::ST_FULL;
        end else begin
          cmd.op    = olpe_pkg::OP_OPEN;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      olpe_pkg::MODE_PUSH_BACK: begin
        if (is_full) begin
          cmd.status = olpe_pkg::ST_FULL;
        end else begin
          cmd.op    = olpe_pkg::OP_OPEN;
          cmd.idx   = olpe_pkg::CMD_IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      olpe_pkg::MODE_POP_FRONT: begin
        if (is_empty) begin
          cmd.status = olpe_pkg::ST_EMPTY;
        end else begin
          cmd.op    = olpe_pkg::OP_CLOSE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      olpe_pkg::MODE_POP_BACK: begin
        if (is_empty) begin
          cmd.status = olpe_pkg::ST_EMPTY;
        end else begin
          cmd.op    = olpe_pkg::OP_CLOSE;
          cmd.idx   = olpe_pkg::CMD_IDX_W'(count_r - CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      olpe_pkg::MODE_CLEAR: begin
        if (is_empty) begin
          cmd.status = olpe_pkg::ST_EMPTY;
        end else begin
          count_nxt = '0;
        end
      end
      olpe_pkg::MODE_INSERT_AFTER: begin
        if (!pos_ok) begin
          cmd.status = olpe_pkg::ST_BADPOS;
        end else if (is_full) begin
          cmd.status = olpe_pkg::ST_FULL;
        end else begin
          cmd.op    = olpe_pkg::OP_OPEN;
          cmd.idx   = olpe_pkg::CMD_IDX_W'(in_position);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      olpe_pkg::MODE_REMOVE_AT: begin
        if (!pos_ok) begin
          cmd.status = olpe_pkg::ST_BADPOS;
        end else begin
          cmd.op    = olpe_pkg::OP_CLOSE;
          cmd.idx   = olpe_pkg::CMD_IDX_W'(in_position - olpe_pkg::POS_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      olpe_pkg::MODE_DUMP: begin
        if (is_empty) begin
          cmd.status = olpe_pkg::ST_EMPTY;
        end else begin
          cmd.op  = olpe_pkg::OP_DUMP;
          cmd.len = olpe_pkg::CMD_LEN_W'(count_r);
        end
      end
      default: begin
        cmd.status = olpe_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd.op == olpe_pkg::OP_OPEN) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("open command without count advance");

endmodule

// ===== src/olpe_queue.sv =====
// Two-entry command queue between front and back ends.
// Depends on olpe_pkg.
module olpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  olpe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output olpe_pkg::cmd_t head_cmd
);

  localparam int unsigned DEPTH = olpe_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  olpe_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign full       = (fill_r == FILL_W'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fill_r != '0))
    else $error("command queue popped while empty");

endmodule

// ===== src/olpe_back.sv =====
// Back end: holds the entry cells, shifts them for edits, rotates them for
// dumps and drives the registered result word. Depends on olpe_pkg.
module olpe_back #(
  parameter int unsigned CAPACITY = olpe_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  olpe_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [olpe_pkg::VAL_W-1:0] out_item_value,
  output logic [olpe_pkg::ST_W-1:0]         out_status,
  output logic                              out_last
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [olpe_pkg::VAL_W-1:0] cell_r   [CAPACITY];
  logic [olpe_pkg::VAL_W-1:0] cell_nxt [CAPACITY];
  logic [IDX_W-1:0]           dump_cnt_r;
  logic                       out_valid_r;
  logic [olpe_pkg::VAL_W-1:0] out_value_r;
  olpe_pkg::status_t          out_status_r;
  logic                       out_last_r;

  logic             advance;
  logic             dump_last;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] len_m1;

  assign advance   = q_valid && (!out_valid_r || !out_stall);
  assign idx       = q_cmd.idx[IDX_W-1:0];
  assign len       = q_cmd.len[CNT_W-1:0];
  assign len_m1    = len - CNT_W'(1);
  assign dump_last = (CNT_W'(dump_cnt_r) == len_m1);
  assign q_pop     = advance && ((q_cmd.op != olpe_pkg::OP_DUMP) || dump_last);

  // Each cell picks from itself, its neighbours, the new value or the front
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [IDX_W-1:0] KI = IDX_W'(k);
    localparam logic [CNT_W-1:0] KC = CNT_W'(k);
    logic [olpe_pkg::VAL_W-1:0] lo_nb;
    logic [olpe_pkg::VAL_W-1:0] hi_nb;

    if (k == 0) begin : g_first
      assign lo_nb = cell_r[k];
    end else begin : g_lo
      assign lo_nb = cell_r[k-1];
    end
    if (k == CAPACITY - 1) begin : g_end
      assign hi_nb = cell_r[k];
    end else begin : g_hi
      assign hi_nb = cell_r[k+1];
    end

    always_comb begin
      cell_nxt[k] = cell_r[k];
      unique case (q_cmd.op)
        olpe_pkg::OP_OPEN: begin
          if (KI == idx) begin
            cell_nxt[k] = q_cmd.value;
          end else if (KI > idx) begin
            cell_nxt[k] = lo_nb;
          end
        end
        olpe_pkg::OP_CLOSE: begin
          if (KI >= idx) begin
            cell_nxt[k] = hi_nb;
          end
        end
        olpe_pkg::OP_DUMP: begin
          if (KC == len_m1) begin
            cell_nxt[k] = cell_r[0];
          end else if (KC < len_m1) begin
            cell_nxt[k] = hi_nb;
          end
        end
        olpe_pkg::OP_REPORT: begin
          cell_nxt[k] = cell_r[k];
        end
        default: begin
          cell_nxt[k] = cell_r[k];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        cell_r[k] <= cell_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dump_cnt_r <= '0;
    end else if (advance && q_cmd.op == olpe_pkg::OP_DUMP) begin
      dump_cnt_r <= dump_last ? '0 : dump_cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= q_cmd.status;
      if (q_cmd.op == olpe_pkg::OP_DUMP) begin
        out_value_r <= cell_r[0];
        out_last_r  <= dump_last;
      end else begin
        out_value_r <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_cmd.op == olpe_pkg::OP_DUMP) |-> (CNT_W'(dump_cnt_r) < len))
    else $error("dump counter ran past list length");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != olpe_pkg::ST_OK) |-> out_last_r)
    else $error("error status word not marked last");

  a_dump_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.op == olpe_pkg::OP_DUMP) |=> (dump_cnt_r == '0))
    else $error("dump counter not rewound after final word");

endmodule

// ===== src/ordered_list_positional_edit.sv =====
// Top level of the ordered list with positional edit.
// Depends on olpe_pkg, olpe_front, olpe_queue and olpe_back.
//
// Input channel (in_valid / in_stall / in_mode, in_position, in_value) takes
// one operation word: push front or back, pop front or back, clear, insert
// after a one-based position, remove at a position, or dump. The result
// channel (out_valid / out_stall / out_item_value, out_status, out_last)
// returns one status word per edit, or one word per stored entry for a dump,
// front first, the final one flagged by out_last. A word moves on a rising
// edge with valid high and stall low.
// The front end classifies a word in the cycle it is accepted against its own
// entry count; a two-word command queue feeds the back end, which shifts all
// cells at once. An edit's status word passes through a queue slot and then
// the result register, so edits flow at one word per cycle unless out_stall,
// in_stall or a dump holds them. A dump holds the back end for all its words,
// rotating the cells past the front cell and back into order.
// rst_n (synchronous, active low) empties the list, the command queue and the
// result register; cell contents stay as they are and are rewritten before use.
// While out_stall is high hold the result register and the back end, let the
// queue fill, then raise in_stall.
module ordered_list_positional_edit #(
  parameter int unsigned CAPACITY = olpe_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [olpe_pkg::MODE_W-1:0]       in_mode,
  input  logic [olpe_pkg::POS_W-1:0]        in_position,
  input  logic signed [olpe_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [olpe_pkg::VAL_W-1:0] out_item_value,
  output logic [olpe_pkg::ST_W-1:0]         out_status,
  output logic                              out_last
);

  // Command word handed from the front end to the queue
  logic           push;
  olpe_pkg::cmd_t push_cmd;
  logic           q_full;

  // Head of the queue as seen by the back end
  logic           head_valid;
  olpe_pkg::cmd_t head_cmd;
  logic           pop;

  // Classify and count; drop nothing, stall when the queue is full
  olpe_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_position (in_position),
    .in_value    (in_value),
    .q_push      (push),
    .q_cmd       (push_cmd),
    .q_full      (q_full)
  );

  // Decouple the two ends so each can hold on its own
  olpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Apply edits to the cells, stream dumps, register each result word
  olpe_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_cmd          (head_cmd),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== dv/tb_ordered_list_positional_edit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_positional_edit: directed edits, then random phases.
// Results are checked against a local list predictor. Depends on olpe_pkg and the block RTL.
module tb_ordered_list_positional_edit;

  localparam int unsigned LIST_CAP = olpe_pkg::CAPACITY_DEF;

  // One result word as it leaves the block
  typedef struct packed {
    logic signed [olpe_pkg::VAL_W-1:0] item_value;
    olpe_pkg::status_t                 status;
    logic                              last;
  } result_word_t;

  // One row of the directed plan; typed rows carry their status in the row
  typedef struct packed {
    olpe_pkg::mode_t             mode;
    logic [olpe_pkg::POS_W-1:0]  pos;
    logic [olpe_pkg::VAL_W-1:0]  value;
    logic                        typed;
    olpe_pkg::status_t           status;
  } edit_row_t;

  typedef enum int { PH_GROW, PH_DRAIN, PH_MIXED } phase_kind_t;

  typedef struct {
    phase_kind_t kind;
    int          items;
    bit          idles;
  } phase_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [olpe_pkg::MODE_W-1:0]       in_mode;
  logic [olpe_pkg::POS_W-1:0]        in_position;
  logic signed [olpe_pkg::VAL_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [olpe_pkg::VAL_W-1:0] out_item_value;
  logic [olpe_pkg::ST_W-1:0]         out_status;
  logic                              out_last;

  // Predicted list contents, front at index 0
  logic signed [olpe_pkg::VAL_W-1:0] list_cells [LIST_CAP];
  int unsigned                       list_len;
  result_word_t                      pending_words [$];

  bit sender_idles;
  bit receiver_stalls;

  int mismatch_count;
  int words_sent;
  int words_checked;
  int full_refusals;
  int dump_count;
  int longest_dump;

  // Directed plan: empty-list cases first, then the extremes of value and
  // position, insert after the last entry, and back to empty again.
  localparam int PLAN_LEN = 25;
  edit_row_t edit_plan [PLAN_LEN] = '{
    '{olpe_pkg::MODE_DUMP,         6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY},
    '{olpe_pkg::MODE_POP_FRONT,    6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY},
    '{olpe_pkg::MODE_POP_BACK,     6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY},
    '{olpe_pkg::MODE_CLEAR,        6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY},
    '{olpe_pkg::MODE_REMOVE_AT,    6'd1,  32'h0000_0000, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_INSERT_AFTER, 6'd0,  32'h0000_0005, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_INSERT_AFTER, 6'd1,  32'h0000_0005, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_PUSH_BACK,    6'd0,  32'h7FFF_FFFF, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_PUSH_FRONT,   6'd0,  32'h8000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_INSERT_AFTER, 6'd2,  32'hFFFF_FFFF, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_INSERT_AFTER, 6'd1,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_INSERT_AFTER, 6'd63, 32'h1234_5678, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_REMOVE_AT,    6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_REMOVE_AT,    6'd5,  32'h0000_0000, 1'b1, olpe_pkg::ST_BADPOS},
    '{olpe_pkg::MODE_DUMP,         6'd0,  32'h0000_0000, 1'b0, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_REMOVE_AT,    6'd4,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_REMOVE_AT,    6'd1,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_POP_BACK,     6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_PUSH_FRONT,   6'd0,  32'h0000_0001, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_DUMP,         6'd0,  32'h0000_0000, 1'b0, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_POP_FRONT,    6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_PUSH_BACK,    6'd0,  32'hA5A5_A5A5, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_CLEAR,        6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_OK},
    '{olpe_pkg::MODE_DUMP,         6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY},
    '{olpe_pkg::MODE_POP_BACK,     6'd0,  32'h0000_0000, 1'b1, olpe_pkg::ST_EMPTY}
  };

  // Random phases after the fill-to-capacity ramp. The first drain phase
  // and the closing phase run without any idling.
  localparam int PHASE_COUNT = 7;
  phase_t run_plan [PHASE_COUNT] = '{
    '{PH_MIXED, 40, 1'b1},
    '{PH_GROW,  60, 1'b1},
    '{PH_DRAIN, 45, 1'b0},
    '{PH_MIXED, 40, 1'b1},
    '{PH_GROW,  50, 1'b1},
    '{PH_DRAIN, 40, 1'b1},
    '{PH_MIXED, 45, 1'b0}
  };

  ordered_list_positional_edit #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item_value(out_item_value),
    .out_status(out_status),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Print one line per bad word and count it
  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------
  function automatic void post_status(input olpe_pkg::status_t st);
    if (st == olpe_pkg::ST_FULL) full_refusals++;
    pending_words.push_back('{'0, st, 1'b1});
  endfunction

  // Open a gap at idx by shifting the tail one place back, then fill it
  function automatic void open_slot(input int unsigned idx,
                                    input logic signed [olpe_pkg::VAL_W-1:0] v);
    for (int unsigned k = list_len; k > idx; k--) list_cells[k] = list_cells[k-1];
    list_cells[idx] = v;
    list_len++;
  endfunction

  // Close the entry at idx by shifting the tail one place forward
  function automatic void close_slot(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
    list_len--;
  endfunction

  // Apply one operation word to the predicted list and queue its results
  function automatic void predict_edit(input olpe_pkg::mode_t m,
                                       input logic [olpe_pkg::POS_W-1:0] pos,
                                       input logic signed [olpe_pkg::VAL_W-1:0] v);
    case (m)
      olpe_pkg::MODE_PUSH_FRONT, olpe_pkg::MODE_PUSH_BACK: begin
        if (list_len >= LIST_CAP) post_status(olpe_pkg::ST_FULL);
        else begin
          open_slot((m == olpe_pkg::MODE_PUSH_FRONT) ? 0 : list_len, v);
          post_status(olpe_pkg::ST_OK);
        end
      end
      olpe_pkg::MODE_POP_FRONT, olpe_pkg::MODE_POP_BACK: begin
        if (list_len == 0) post_status(olpe_pkg::ST_EMPTY);
        else begin
          close_slot((m == olpe_pkg::MODE_POP_FRONT) ? 0 : list_len - 1);
          post_status(olpe_pkg::ST_OK);
        end
      end
      olpe_pkg::MODE_CLEAR: begin
        if (list_len == 0) post_status(olpe_pkg::ST_EMPTY);
        else begin
          list_len = 0;
          post_status(olpe_pkg::ST_OK);
        end
      end
      olpe_pkg::MODE_INSERT_AFTER: begin
        // position is judged before fullness
        if (pos == 0 || pos > list_len) post_status(olpe_pkg::ST_BADPOS);
        else if (list_len >= LIST_CAP) post_status(olpe_pkg::ST_FULL);
        else begin
          open_slot(pos, v);
          post_status(olpe_pkg::ST_OK);
        end
      end
      olpe_pkg::MODE_REMOVE_AT: begin
        if (pos == 0 || pos > list_len) post_status(olpe_pkg::ST_BADPOS);
        else begin
          close_slot(pos - 1);
          post_status(olpe_pkg::ST_OK);
        end
      end
      default: begin
        if (list_len == 0) post_status(olpe_pkg::ST_EMPTY);
        else begin
          dump_count++;
          if (list_len > longest_dump) longest_dump = list_len;
          for (int unsigned k = 0; k < list_len; k++)
            pending_words.push_back('{list_cells[k], olpe_pkg::ST_OK, (k + 1 == list_len)});
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Offer one word, hold it until accepted, then queue what it should give.
  // A typed row replaces the predicted status word with the one in the row.
  task automatic send_word(input olpe_pkg::mode_t m, input logic [olpe_pkg::POS_W-1:0] pos,
                           input logic [olpe_pkg::VAL_W-1:0] v, input bit typed,
                           input olpe_pkg::status_t st);
    int unsigned base;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_position <= pos;
    in_value    <= v;
    do @(posedge clk); while (in_stall);
    base = pending_words.size();
    predict_edit(m, pos, v);
    if (typed) begin
      while (pending_words.size() > base) void'(pending_words.pop_back());
      pending_words.push_back('{'0, st, 1'b1});
    end
    words_sent++;
  endtask

  // Values lean on the sign boundaries now and then
  function automatic logic [olpe_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a position inside the list, sometimes zero, one past the end
  // or anywhere in the field
  function automatic logic [olpe_pkg::POS_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return olpe_pkg::POS_W'($urandom_range(0, 63));
      1:       return olpe_pkg::POS_W'(list_len + 1);
      2:       return '0;
      default: return olpe_pkg::POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
    endcase
  endfunction

  function automatic olpe_pkg::mode_t pick_grow_mode();
    case ($urandom_range(0, 2))
      0:       return olpe_pkg::MODE_PUSH_FRONT;
      1:       return olpe_pkg::MODE_PUSH_BACK;
      default: return olpe_pkg::MODE_INSERT_AFTER;
    endcase
  endfunction

  function automatic olpe_pkg::mode_t pick_shrink_mode();
    case ($urandom_range(0, 2))
      0:       return olpe_pkg::MODE_POP_FRONT;
      1:       return olpe_pkg::MODE_POP_BACK;
      default: return olpe_pkg::MODE_REMOVE_AT;
    endcase
  endfunction

  task automatic random_edit(input phase_kind_t kind);
    olpe_pkg::mode_t m;
    m = olpe_pkg::mode_t'(olpe_pkg::MODE_W'($urandom_range(0, 7)));
    if (kind == PH_GROW) begin
      if ($urandom_range(0, 3) != 0) m = pick_grow_mode();
      else if (m == olpe_pkg::MODE_CLEAR) m = olpe_pkg::MODE_DUMP;  // keep growth going
    end else if (kind == PH_DRAIN && $urandom_range(0, 3) != 0) begin
      m = pick_shrink_mode();
    end
    send_word(m, pick_position(), pick_value(), 1'b0, olpe_pkg::ST_OK);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: stall in random bursts while allowed
  // ---------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result word against the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word value %h status %0d last %b",
                                out_item_value, out_status, out_last));
      end else begin
        want = pending_words.pop_front();
        if (out_item_value !== want.item_value || out_status !== want.status ||
            out_last !== want.last)
          note_mismatch($sformatf("got value %h status %0d last %b, wanted %h %s %b",
                                  out_item_value, out_status, out_last,
                                  want.item_value, want.status.name(), want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  // Drop the offered word and hold the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_mode         <= olpe_pkg::MODE_PUSH_FRONT;
    in_position     <= '0;
    in_value        <= '0;
    rst_n           <= 1'b0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    list_len        = 0;
    mismatch_count  = 0;
    words_sent      = 0;
    words_checked   = 0;
    full_refusals   = 0;
    dump_count      = 0;
    longest_dump    = 0;

    // Hold reset once, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan
    for (int i = 0; i < PLAN_LEN; i++)
      send_word(edit_plan[i].mode, edit_plan[i].pos, edit_plan[i].value,
                edit_plan[i].typed, edit_plan[i].status);

    // Pause the sender until every result is back
    drain_results();

    // Fill to capacity with random grow operations, then probe the full list
    while (list_len < LIST_CAP) begin
      if (list_len == 0)
        send_word(olpe_pkg::MODE_PUSH_BACK, '0, pick_value(), 1'b0, olpe_pkg::ST_OK);
      else
        send_word(pick_grow_mode(), olpe_pkg::POS_W'($urandom_range(1, list_len)),
                  pick_value(), 1'b0, olpe_pkg::ST_OK);
    end
    send_word(olpe_pkg::MODE_PUSH_FRONT, '0, pick_value(), 1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_PUSH_BACK, '0, pick_value(), 1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_INSERT_AFTER, olpe_pkg::POS_W'(LIST_CAP), pick_value(),
              1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_INSERT_AFTER, olpe_pkg::POS_W'($urandom_range(1, LIST_CAP - 1)),
              pick_value(), 1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_INSERT_AFTER, olpe_pkg::POS_W'(LIST_CAP + 1), pick_value(),
              1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_DUMP, '0, '0, 1'b0, olpe_pkg::ST_OK);
    send_word(olpe_pkg::MODE_REMOVE_AT, olpe_pkg::POS_W'($urandom_range(1, LIST_CAP)), '0,
              1'b0, olpe_pkg::ST_OK);
    drain_results();

    // Random phases; drain between them so each starts from a settled block
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      sender_idles    = run_plan[ph].idles;
      receiver_stalls = run_plan[ph].idles;
      for (int n = 0; n < run_plan[ph].items; n++) random_edit(run_plan[ph].kind);
      if (ph + 1 < PHASE_COUNT) drain_results();
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (16) @(posedge clk);

    $display("Covered %0d operation words and %0d result words, %0d dumps (longest %0d).",
             words_sent, words_checked, dump_count, longest_dump);
    $display("Full-list refusals seen: %0d, bad words: %0d.", full_refusals, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung run: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/olpe_pkg.sv
src/olpe_front.sv
src/olpe_queue.sv
src/olpe_back.sv
src/ordered_list_positional_edit.sv
dv/tb_ordered_list_positional_edit.sv
